// File: design/qoi_dec_pkg.sv
package qoi_dec_pkg;

   localparam int CFG_BITS      = 16;
   localparam int DIM_BITS_DEF  = 16;
   localparam int INDEX_ENTRIES = 64;
   localparam int INDEX_BITS    = $clog2(INDEX_ENTRIES);
   localparam int RUN_BITS      = INDEX_BITS + 1;

   // Configuration register indexes.
   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   // Multi-byte chunk in progress.
   localparam logic [1:0] OP_NONE = 2'd0;
   localparam logic [1:0] OP_RGB  = 2'd1;
   localparam logic [1:0] OP_RGBA = 2'd2;
   localparam logic [1:0] OP_LUMA = 2'd3;

   // Chunk tags.
   localparam logic [7:0] TAG_RGB  = 8'hfe;
   localparam logic [7:0] TAG_RGBA = 8'hff;
   localparam logic [1:0] TAG_INDEX = 2'b00;
   localparam logic [1:0] TAG_DIFF  = 2'b01;
   localparam logic [1:0] TAG_LUMA  = 2'b10;
   localparam logic [1:0] TAG_RUN   = 2'b11;

   localparam logic [31:0] START_PIXEL = 32'h0000_00ff;

   typedef struct packed {
      logic accept;
      logic fetch;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic go_fetch;
      logic go_emit;
      logic emit_done;
   } status_type;

   // Colour index position of an RGBA word: (3r + 5g + 7b + 11a) mod 64.
   function automatic logic [INDEX_BITS-1:0] pixel_hash(input logic [31:0] pix);
      logic [INDEX_BITS-1:0] r6, g6, b6, a6;
      r6 = pix[24 +: INDEX_BITS];
      g6 = pix[16 +: INDEX_BITS];
      b6 = pix[8 +: INDEX_BITS];
      a6 = pix[0 +: INDEX_BITS];
      return r6 * INDEX_BITS'(3) + g6 * INDEX_BITS'(5) + b6 * INDEX_BITS'(7)
             + a6 * INDEX_BITS'(11);
   endfunction

endpackage

// File: design/qoi_dec_ctrl.sv
module qoi_dec_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  qoi_dec_pkg::status_type status,
   output qoi_dec_pkg::cmd_type    cmd
);
   import qoi_dec_pkg::*;

   localparam logic [1:0] ST_ACCEPT = 2'd0;
   localparam logic [1:0] ST_FETCH  = 2'd1;
   localparam logic [1:0] ST_EMIT   = 2'd2;

   logic [1:0] state_ff, state_in;

   assign req_stall  = (state_ff != ST_ACCEPT);
   assign cmd.accept = (state_ff == ST_ACCEPT) && req_valid;
   assign cmd.fetch  = (state_ff == ST_FETCH);
   assign cmd.emit   = (state_ff == ST_EMIT);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_ACCEPT: begin
            if (cmd.accept) begin
               if (status.go_fetch) begin
                  state_in = ST_FETCH;
               end else if (status.go_emit) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_FETCH: state_in = ST_EMIT;
         ST_EMIT: begin
            if (status.emit_done) begin
               state_in = ST_ACCEPT;
            end
         end
         default: state_in = ST_ACCEPT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCEPT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/qoi_dec_dp.sv
module qoi_dec_dp #(
   parameter int DIM_BITS = qoi_dec_pkg::DIM_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  qoi_dec_pkg::cmd_type          cmd,
   output qoi_dec_pkg::status_type       status,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_image_start,
   input  logic                          csr_write_enable,
   input  logic                          csr_index,
   input  logic [qoi_dec_pkg::CFG_BITS-1:0] csr_write_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_red,
   output logic [7:0]                    rsp_green,
   output logic [7:0]                    rsp_blue,
   output logic [7:0]                    rsp_alpha,
   output logic [DIM_BITS-1:0]           rsp_pixel_x,
   output logic [DIM_BITS-1:0]           rsp_pixel_y,
   output logic                          rsp_last_of_item,
   output logic                          rsp_last_of_image
);
   import qoi_dec_pkg::*;

   localparam int CMP_BITS = ((DIM_BITS > CFG_BITS) ? DIM_BITS : CFG_BITS) + 1;

   // Configuration.
   logic [CFG_BITS-1:0] width_ff, height_ff;

   // Decoder state.
   logic [31:0]            prev_ff, prev_in;
   logic [1:0]             pending_ff, pending_in;
   logic [2:0]             need_ff, need_in;
   logic [23:0]            partial_ff, partial_in;
   logic [DIM_BITS-1:0]    col_ff, col_in;
   logic [DIM_BITS-1:0]    row_ff, row_in;
   logic                   done_ff, done_in;
   logic [RUN_BITS-1:0]    remain_ff, remain_in;
   logic [INDEX_ENTRIES-1:0] valid_ff, valid_in;

   // Colour index memory and its registered read.
   logic [31:0]            index_mem [INDEX_ENTRIES];
   logic [31:0]            rd_data_ff;
   logic                   rd_valid_ff;
   logic [INDEX_BITS-1:0]  rd_addr;
   logic [INDEX_BITS-1:0]  wr_addr;

   // Result word register.
   logic                   out_valid_ff, out_valid_in;
   logic [31:0]            out_pix_ff;
   logic [DIM_BITS-1:0]    out_x_ff, out_y_ff;
   logic                   out_last_item_ff, out_last_image_ff;

   // Values seen by the byte after an optional image start.
   logic [31:0]   eff_prev;
   logic [1:0]    eff_pending;
   logic [2:0]    eff_need;
   logic [23:0]   eff_partial;
   logic          eff_done;

   logic [7:0]    r, g, bl, a, vg;
   logic [23:0]   shifted;
   logic          go_fetch, go_emit;
   logic [RUN_BITS-1:0] run_count;

   logic          out_free, row_end, img_end, send;
   logic [CMP_BITS-1:0] col_next_ext;

   assign rd_addr = req_data_byte[INDEX_BITS-1:0];
   assign wr_addr = pixel_hash(prev_ff);

   always_comb begin
      eff_prev    = req_image_start ? START_PIXEL : prev_ff;
      eff_pending = req_image_start ? OP_NONE : pending_ff;
      eff_need    = req_image_start ? 3'd0 : need_ff;
      eff_partial = req_image_start ? 24'd0 : partial_ff;
      eff_done    = req_image_start ? 1'b0 : done_ff;
   end

   // Chunk decode for the byte being accepted.
   always_comb begin
      r          = eff_prev[31:24];
      g          = eff_prev[23:16];
      bl         = eff_prev[15:8];
      a          = eff_prev[7:0];
      vg         = {2'b00, eff_partial[5:0]} - 8'd32;
      shifted    = {eff_partial[15:0], req_data_byte};
      pending_in = eff_pending;
      need_in    = eff_need;
      partial_in = eff_partial;
      go_fetch   = 1'b0;
      go_emit    = 1'b0;
      run_count  = RUN_BITS'(1);
      if (eff_done) begin
         go_emit = 1'b0;
      end else if (eff_pending != OP_NONE) begin
         priority if (eff_pending == OP_LUMA) begin
            r       = r + vg - 8'd8 + {4'd0, req_data_byte[7:4]};
            g       = g + vg;
            bl      = bl + vg - 8'd8 + {4'd0, req_data_byte[3:0]};
            go_emit = 1'b1;
         end else if (eff_need > 3'd1) begin
            partial_in = shifted;
            need_in    = eff_need - 3'd1;
         end else if (eff_pending == OP_RGB) begin
            r       = shifted[23:16];
            g       = shifted[15:8];
            bl      = shifted[7:0];
            go_emit = 1'b1;
         end else begin
            r       = eff_partial[23:16];
            g       = eff_partial[15:8];
            bl      = eff_partial[7:0];
            a       = req_data_byte;
            go_emit = 1'b1;
         end
         if (go_emit) begin
            pending_in = OP_NONE;
            need_in    = 3'd0;
            partial_in = 24'd0;
         end
      end else if (req_data_byte == TAG_RGB) begin
         pending_in = OP_RGB;
         need_in    = 3'd3;
         partial_in = 24'd0;
      end else if (req_data_byte == TAG_RGBA) begin
         pending_in = OP_RGBA;
         need_in    = 3'd4;
         partial_in = 24'd0;
      end else begin
         unique case (req_data_byte[7:6])
            TAG_INDEX: go_fetch = 1'b1;
            TAG_DIFF: begin
               r       = r + {6'd0, req_data_byte[5:4]} - 8'd2;
               g       = g + {6'd0, req_data_byte[3:2]} - 8'd2;
               bl      = bl + {6'd0, req_data_byte[1:0]} - 8'd2;
               go_emit = 1'b1;
            end
            TAG_LUMA: begin
               pending_in = OP_LUMA;
               need_in    = 3'd1;
               partial_in = {18'd0, req_data_byte[5:0]};
            end
            TAG_RUN: begin
               run_count = {1'b0, req_data_byte[5:0]} + RUN_BITS'(1);
               go_emit   = 1'b1;
            end
            default: go_emit = 1'b0;
         endcase
      end
   end

   // Pixel emission from the previous pixel.
   assign out_free     = !out_valid_ff || !rsp_stall;
   assign send         = cmd.emit && out_free;
   assign col_next_ext = CMP_BITS'(col_ff) + CMP_BITS'(1);
   assign row_end      = col_next_ext >= CMP_BITS'(width_ff);
   assign img_end      = row_end && ((CMP_BITS'(row_ff) + CMP_BITS'(1)) >= CMP_BITS'(height_ff));

   assign status.go_fetch  = go_fetch;
   assign status.go_emit   = go_emit;
   assign status.emit_done = send && ((remain_ff == RUN_BITS'(1)) || img_end);

   always_comb begin
      prev_in      = prev_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      done_in      = done_ff;
      remain_in    = remain_ff;
      valid_in     = valid_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      if (cmd.accept) begin
         if (req_image_start) begin
            col_in   = '0;
            row_in   = '0;
            done_in  = 1'b0;
            valid_in = '0;
            prev_in  = START_PIXEL;
         end
         if (go_emit) begin
            prev_in = {r, g, bl, a};
         end
         remain_in = run_count;
      end
      if (cmd.fetch) begin
         prev_in = rd_valid_ff ? rd_data_ff : 32'd0;
      end
      if (cmd.emit) begin
         // The index entry is rewritten with the same word on every emit cycle.
         valid_in[wr_addr] = 1'b1;
      end
      if (send) begin
         out_valid_in = 1'b1;
         remain_in    = remain_ff - RUN_BITS'(1);
         if (row_end) begin
            col_in = '0;
            row_in = row_ff + DIM_BITS'(1);
         end else begin
            col_in = col_ff + DIM_BITS'(1);
         end
         if (img_end) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= CFG_BITS'(1);
         height_ff    <= CFG_BITS'(1);
         prev_ff      <= START_PIXEL;
         pending_ff   <= OP_NONE;
         need_ff      <= 3'd0;
         partial_ff   <= 24'd0;
         col_ff       <= '0;
         row_ff       <= '0;
         done_ff      <= 1'b0;
         remain_ff    <= '0;
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_IMAGE_WIDTH:  width_ff  <= csr_write_data;
               CSR_IMAGE_HEIGHT: height_ff <= csr_write_data;
               default:          width_ff  <= width_ff;
            endcase
         end
         prev_ff      <= prev_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         done_ff      <= done_in;
         remain_ff    <= remain_in;
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
         if (cmd.accept) begin
            pending_ff <= pending_in;
            need_ff    <= need_in;
            partial_ff <= partial_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         index_mem[wr_addr] <= prev_ff;
      end
      if (cmd.accept) begin
         rd_data_ff  <= index_mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr] && !req_image_start;
      end
   end

   always_ff @(posedge clock) begin
      if (send) begin
         out_pix_ff        <= prev_ff;
         out_x_ff          <= col_ff;
         out_y_ff          <= row_ff;
         out_last_item_ff  <= (remain_ff == RUN_BITS'(1)) || img_end;
         out_last_image_ff <= img_end;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_red           = out_pix_ff[31:24];
   assign rsp_green         = out_pix_ff[23:16];
   assign rsp_blue          = out_pix_ff[15:8];
   assign rsp_alpha         = out_pix_ff[7:0];
   assign rsp_pixel_x       = out_x_ff;
   assign rsp_pixel_y       = out_y_ff;
   assign rsp_last_of_item  = out_last_item_ff;
   assign rsp_last_of_image = out_last_image_ff;

endmodule

// File: design/qoi_image_decoder_unit.sv
// QOI pixel stream decoder: takes one chunk byte per word (header removed) and
// delivers decoded RGBA pixels with their column and row in raster order.
// A byte that only gathers part of a chunk is accepted straight away; a byte
// that completes a pixel holds the input while its pixels are delivered, and
// an INDEX chunk first reads the 64-entry colour index memory.
// A RUN byte therefore holds the input until its run or the image ends.
// The single result register lets one pixel leave per cycle while the
// result side does not stall. The colour index is cleared by per-entry
// valid bits, so an image start needs no separate clearing pass.
module qoi_image_decoder_unit #(
   parameter int DIM_BITS = qoi_dec_pkg::DIM_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_image_start,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_red,
   output logic [7:0]                    rsp_green,
   output logic [7:0]                    rsp_blue,
   output logic [7:0]                    rsp_alpha,
   output logic [DIM_BITS-1:0]           rsp_pixel_x,
   output logic [DIM_BITS-1:0]           rsp_pixel_y,
   output logic                          rsp_last_of_item,
   output logic                          rsp_last_of_image,
   input  logic                          csr_write_enable,
   input  logic                          csr_index,
   input  logic [qoi_dec_pkg::CFG_BITS-1:0] csr_write_data
);
   import qoi_dec_pkg::*;

   cmd_type    cmd;
   status_type status;

   qoi_dec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   qoi_dec_dp #(
      .DIM_BITS (DIM_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_data_byte     (req_data_byte),
      .req_image_start   (req_image_start),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_alpha         (rsp_alpha),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_last_of_item  (rsp_last_of_item),
      .rsp_last_of_image (rsp_last_of_image)
   );

endmodule
